// ----- sv/bad_pkg.sv -----
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the box average downscaler
// Field widths, register codes, item payloads and sequencer codes.
// ----------------------------------------------------------------------------
package bad_pkg;

  // widths fixed by the item and register formats
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned AVG_W     = 16;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned AREA_W    = 2 * CFG_W;
  localparam int unsigned CMP_W     =
    ((SUM_W > AREA_W + AVG_W) ? SUM_W : (AREA_W + AVG_W)) + 1;
  localparam int unsigned DIV_CNT_W = 4;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_TARGET_SIZE  = 2'd2
  } cfg_idx_e;

  // setup sequencer states
  typedef enum logic [1:0] {
    SEQ_LOAD,
    SEQ_STEP,
    SEQ_IDLE
  } seq_state_e;

  // quotients worked out by the setup divider, in order
  typedef enum logic [2:0] {
    OP_FACTOR,
    OP_WIDTH_CAND,
    OP_HEIGHT_CAND,
    OP_WIDTH_CUR,
    OP_HEIGHT_CUR
  } div_op_e;

  // input item
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
  } pix_item_t;

  // result item
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } avg_item_t;

  // one stage of the averaging divider
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [AREA_W-1:0] den;
    logic [AVG_W-1:0]  quo;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              last;
  } div_data_t;

endpackage

// ----- sv/bad_stream_if.sv -----
// ----------------------------------------------------------------------------
// bad_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per channel.
// ----------------------------------------------------------------------------
interface bad_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ----- sv/box_average_downscale.sv -----
// ----------------------------------------------------------------------------
// box_average_downscale: integer factor box filter downsampler
// Averages factor-by-factor squares of a raster image into one result each.
// ----------------------------------------------------------------------------
// Sustained rate is one pixel item per clock while setup is idle and the output
// is not stalled; a result passes the stage 1 register (the column store
// read-modify-write), the divider input register and the sixteen stages of
// the averaging divider, the last driving the output. After reset and after
// every configuration write the input is held off while one shared 13-bit
// serial divider derives the block factor and the kept width and height (five
// quotients). A stalled output freezes the whole pipeline. The factor is taken
// at the first pixel of each frame; with factor 1 every pixel passes straight
// through. Column sums live in a MAX_OUT_WIDTH deep single-port-write memory.
// ----------------------------------------------------------------------------
module box_average_downscale #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_OUT_WIDTH = 2048,
  parameter int unsigned PIXEL_BITS    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bad_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bad_pkg::CFG_W-1:0]  cfg_wdata_i,
  bad_stream_if.sink                 pix_i,
  bad_stream_if.source               avg_o
);

  import bad_pkg::*;

  localparam int unsigned DimMax  = (1 << CFG_W) - 1;
  localparam int unsigned MaxDim  = (MAX_WIDTH > DimMax) ? DimMax : MAX_WIDTH;
  localparam int unsigned AddrW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned PixKeep = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam logic [PIX_W-1:0] PixMask = PIX_W'((64'd1 << PixKeep) - 64'd1);
  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(CFG_W - 1);

  // configuration registers
  logic [CFG_W-1:0] width_q, height_q, target_q;
  logic [CFG_W-1:0] w_eff, h_eff, t_eff, m_eff;

  // setup divider
  seq_state_e        seq_state_q, seq_state_d;
  div_op_e           op_q, op_d;
  logic [CFG_W-1:0]  sq_num_q, sq_num_d;
  logic [CFG_W-1:0]  sq_den_q, sq_den_d;
  logic [CFG_W-1:0]  sq_rem_q, sq_rem_d;
  logic [CFG_W-1:0]  sq_quo_q, sq_quo_d;
  logic [DIV_CNT_W-1:0] sq_cnt_q, sq_cnt_d;
  logic [CFG_W:0]    sq_shift;
  logic              sq_take;
  logic              seq_done;
  logic [CFG_W-1:0]  seq_lim;

  // derived geometry: candidate for the next frame and current frame
  logic [CFG_W-1:0]  fc_q, dwc_q, wlimc_q, dhc_q, hlimc_q;
  logic [AREA_W-1:0] areac_q;
  logic [CFG_W-1:0]  f_q, dw_q, wlim_q, dh_q, hlim_q;
  logic [AREA_W-1:0] area_q;

  // position and accumulation state
  logic [POS_W-1:0]  in_col_q, in_col_d, in_row_q, in_row_d;
  logic [POS_W-1:0]  cdiv_q, cdiv_d, rdiv_q, rdiv_d;
  logic [CFG_W-1:0]  cmod_q, cmod_d, band_q, band_d, gcol_q, gcol_d;
  logic [SUM_W-1:0]  run_q, run_d;

  // stage 0 signals
  logic              en, accept, frame_start;
  logic [CFG_W-1:0]  f_cur, dw_cur, wlim_cur, dh_cur, hlim_cur;
  logic [AREA_W-1:0] area_cur;
  logic [POS_W-1:0]  cdiv_cur, rdiv_cur;
  logic [CFG_W-1:0]  cmod_cur, band_cur, gcol_cur;
  logic [SUM_W-1:0]  run_cur, run_add;
  logic [PIX_W-1:0]  pix;
  logic              row_end, frame_end, pass, in_region, grp_done, g_ok;
  logic              band_last, mem_op, emit;
  logic [31:0]       g_ext;

  // stage 1 registers
  logic              s1_valid_q;
  logic              s1_mem_q, s1_first_q, s1_emit_q, s1_pass_q, s1_last_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic [SUM_W-1:0]  s1_add_q, rd_q, col_sum;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [AREA_W-1:0] s1_area_q;
  logic [POS_W-1:0]  s1_col_q, s1_row_q;

  // column sum store
  logic [SUM_W-1:0]  col_mem [MAX_OUT_WIDTH];

  // averaging divider pipeline
  logic [AVG_W:0]    dv_valid_q;
  div_data_t         dv_data_q [AVG_W+1];
  div_data_t         dv_next [AVG_W];
  div_data_t         dv_load;

  // clamped register views
  assign w_eff = (width_q == '0) ? CFG_W'(1) :
                 (width_q > CFG_W'(MaxDim)) ? CFG_W'(MaxDim) : width_q;
  assign h_eff = (height_q == '0) ? CFG_W'(1) :
                 (height_q > CFG_W'(MaxDim)) ? CFG_W'(MaxDim) : height_q;
  assign t_eff = (target_q == '0) ? CFG_W'(1) : target_q;
  assign m_eff = (w_eff < h_eff) ? w_eff : h_eff;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      target_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_TARGET_SIZE:  target_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // setup sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q <= SEQ_LOAD;
      op_q        <= OP_FACTOR;
    end else begin
      seq_state_q <= seq_state_d;
      op_q        <= op_d;
    end
  end

  // restoring divide step
  assign sq_shift = {sq_rem_q, sq_quo_q[CFG_W-1]};
  assign sq_take  = sq_shift >= {1'b0, sq_den_q};

  // setup sequencer next state and datapath
  always_comb begin
    seq_state_d = seq_state_q;
    op_d        = op_q;
    sq_num_d    = sq_num_q;
    sq_den_d    = sq_den_q;
    sq_rem_d    = sq_rem_q;
    sq_quo_d    = sq_quo_q;
    sq_cnt_d    = sq_cnt_q;
    seq_done    = 1'b0;
    unique case (seq_state_q)
      SEQ_LOAD: begin
        unique case (op_q)
          OP_FACTOR:      begin sq_num_d = m_eff; sq_den_d = t_eff; end
          OP_WIDTH_CAND:  begin sq_num_d = w_eff; sq_den_d = fc_q;  end
          OP_HEIGHT_CAND: begin sq_num_d = h_eff; sq_den_d = fc_q;  end
          OP_WIDTH_CUR:   begin sq_num_d = w_eff; sq_den_d = f_q;   end
          OP_HEIGHT_CUR:  begin sq_num_d = h_eff; sq_den_d = f_q;   end
          default:        begin sq_num_d = m_eff; sq_den_d = t_eff; end
        endcase
        sq_rem_d    = '0;
        sq_quo_d    = sq_num_d;
        sq_cnt_d    = '0;
        seq_state_d = SEQ_STEP;
      end
      SEQ_STEP: begin
        sq_rem_d = sq_take ? CFG_W'(sq_shift - {1'b0, sq_den_q}) : sq_shift[CFG_W-1:0];
        sq_quo_d = {sq_quo_q[CFG_W-2:0], sq_take};
        sq_cnt_d = sq_cnt_q + DIV_CNT_W'(1);
        if (sq_cnt_q == DivLast) begin
          seq_done = 1'b1;
          if (op_q == OP_HEIGHT_CUR) begin
            seq_state_d = SEQ_IDLE;
          end else begin
            op_d        = div_op_e'(3'(op_q) + 3'd1);
            seq_state_d = SEQ_LOAD;
          end
        end
      end
      SEQ_IDLE: ;
      default: seq_state_d = SEQ_LOAD;
    endcase
    // any register write restarts the derivation
    if (cfg_we_i) begin
      seq_state_d = SEQ_LOAD;
      op_d        = OP_FACTOR;
    end
  end

  assign seq_lim = sq_num_q - sq_rem_d;

  always_ff @(posedge clk_i) begin
    sq_num_q <= sq_num_d;
    sq_den_q <= sq_den_d;
    sq_rem_q <= sq_rem_d;
    sq_quo_q <= sq_quo_d;
    sq_cnt_q <= sq_cnt_d;
  end

  // candidate geometry from the setup divider
  always_ff @(posedge clk_i) begin
    areac_q <= AREA_W'(fc_q) * AREA_W'(fc_q);
    if (seq_done) begin
      case (op_q)
        OP_FACTOR:      fc_q <= (sq_quo_d == '0) ? CFG_W'(1) : sq_quo_d;
        OP_WIDTH_CAND:  begin dwc_q <= sq_quo_d; wlimc_q <= seq_lim; end
        OP_HEIGHT_CAND: begin dhc_q <= sq_quo_d; hlimc_q <= seq_lim; end
        default: ;
      endcase
    end
  end

  // current frame geometry: latched at frame start, refreshed by the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= CFG_W'(1);
    end else if (accept && frame_start) begin
      f_q <= fc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_start) begin
      area_q <= areac_q;
      dw_q   <= dwc_q;
      wlim_q <= wlimc_q;
      dh_q   <= dhc_q;
      hlim_q <= hlimc_q;
    end else if (seq_done && op_q == OP_WIDTH_CUR) begin
      dw_q   <= sq_quo_d;
      wlim_q <= seq_lim;
    end else if (seq_done && op_q == OP_HEIGHT_CUR) begin
      dh_q   <= sq_quo_d;
      hlim_q <= seq_lim;
    end
  end

  // handshake
  assign en           = !dv_valid_q[AVG_W] || avg_o.ready;
  assign pix_i.ready  = en && (seq_state_q == SEQ_IDLE);
  assign accept       = pix_i.valid && pix_i.ready;

  // stage 0: position, region and group decisions
  assign frame_start = (in_col_q == '0) && (in_row_q == '0);
  assign f_cur    = frame_start ? fc_q    : f_q;
  assign area_cur = frame_start ? areac_q : area_q;
  assign dw_cur   = frame_start ? dwc_q   : dw_q;
  assign wlim_cur = frame_start ? wlimc_q : wlim_q;
  assign dh_cur   = frame_start ? dhc_q   : dh_q;
  assign hlim_cur = frame_start ? hlimc_q : hlim_q;
  assign cdiv_cur = frame_start ? '0 : cdiv_q;
  assign cmod_cur = frame_start ? '0 : cmod_q;
  assign rdiv_cur = frame_start ? '0 : rdiv_q;
  assign band_cur = frame_start ? '0 : band_q;
  assign gcol_cur = frame_start ? '0 : gcol_q;
  assign run_cur  = frame_start ? '0 : run_q;

  assign pix       = pix_i.payload.pixel & PixMask;
  assign row_end   = (CFG_W'(in_col_q) + CFG_W'(1)) >= w_eff;
  assign frame_end = row_end && ((CFG_W'(in_row_q) + CFG_W'(1)) >= h_eff);
  assign pass      = f_cur <= CFG_W'(1);
  assign in_region = (CFG_W'(in_col_q) < wlim_cur) && (CFG_W'(in_row_q) < hlim_cur);
  assign run_add   = run_cur + SUM_W'(pix);
  assign grp_done  = in_region && ((CFG_W'(1) + gcol_cur) >= f_cur);
  assign g_ext     = 32'(cdiv_cur);
  assign g_ok      = g_ext < MAX_OUT_WIDTH;
  assign band_last = (band_cur + CFG_W'(1)) >= f_cur;
  assign mem_op    = !pass && grp_done && g_ok;
  assign emit      = pass || (mem_op && band_last);

  // stage 0: next position and accumulation state
  always_comb begin
    in_col_d = POS_W'(in_col_q + POS_W'(1));
    in_row_d = in_row_q;
    cdiv_d   = cdiv_cur;
    cmod_d   = cmod_cur + CFG_W'(1);
    rdiv_d   = rdiv_cur;
    band_d   = band_cur;
    gcol_d   = gcol_cur;
    run_d    = run_cur;
    if (cmod_d == f_cur) begin
      cmod_d = '0;
      cdiv_d = POS_W'(cdiv_cur + POS_W'(1));
    end
    if (!pass && in_region) begin
      if (grp_done) begin
        gcol_d = '0;
        run_d  = '0;
      end else begin
        gcol_d = gcol_cur + CFG_W'(1);
        run_d  = run_add;
      end
    end
    if (frame_end) begin
      in_col_d = '0;
      in_row_d = '0;
      cdiv_d   = '0;
      cmod_d   = '0;
      rdiv_d   = '0;
      band_d   = '0;
      gcol_d   = '0;
      run_d    = '0;
    end else if (row_end) begin
      in_col_d = '0;
      in_row_d = POS_W'(in_row_q + POS_W'(1));
      cdiv_d   = '0;
      cmod_d   = '0;
      gcol_d   = '0;
      run_d    = '0;
      if (band_last) begin
        band_d = '0;
        rdiv_d = POS_W'(rdiv_cur + POS_W'(1));
      end else begin
        band_d = band_cur + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      cdiv_q   <= '0;
      cmod_q   <= '0;
      rdiv_q   <= '0;
      band_q   <= '0;
      gcol_q   <= '0;
      run_q    <= '0;
    end else if (accept) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      cdiv_q   <= cdiv_d;
      cmod_q   <= cmod_d;
      rdiv_q   <= rdiv_d;
      band_q   <= band_d;
      gcol_q   <= gcol_d;
      run_q    <= run_d;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mem_q   <= mem_op;
      s1_first_q <= band_cur == '0;
      s1_emit_q  <= emit;
      s1_pass_q  <= pass;
      s1_addr_q  <= g_ext[AddrW-1:0];
      s1_add_q   <= run_add;
      s1_pix_q   <= pix;
      s1_area_q  <= area_cur;
      s1_col_q   <= pass ? in_col_q : cdiv_cur;
      s1_row_q   <= pass ? in_row_q : rdiv_cur;
      s1_last_q  <= pass ? frame_end :
                    ((CFG_W'(cdiv_cur) + CFG_W'(1)) == dw_cur) &&
                    ((CFG_W'(rdiv_cur) + CFG_W'(1)) == dh_cur);
    end
  end

  // column sum store: read in stage 0, write back in stage 1
  assign col_sum = s1_first_q ? s1_add_q : SUM_W'(rd_q + s1_add_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= col_mem[g_ext[AddrW-1:0]];
      if (s1_valid_q && s1_mem_q) begin
        col_mem[s1_addr_q] <= col_sum;
      end
    end
  end

  // divider input: block sum over area, or the pixel over one
  always_comb begin
    dv_load.rem  = s1_pass_q ? SUM_W'(s1_pix_q) : col_sum;
    dv_load.den  = s1_pass_q ? AREA_W'(1) : s1_area_q;
    dv_load.quo  = '0;
    dv_load.col  = s1_col_q;
    dv_load.row  = s1_row_q;
    dv_load.last = s1_last_q;
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < AVG_W; j++) begin : g_div
    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] den_sh;
    logic             take;

    assign num_ext = CMP_W'(dv_data_q[j].rem);
    assign den_sh  = CMP_W'(dv_data_q[j].den) << (AVG_W - 1 - j);
    assign take    = num_ext >= den_sh;

    always_comb begin
      dv_next[j] = dv_data_q[j];
      if (take) begin
        dv_next[j].rem = SUM_W'(num_ext - den_sh);
      end
      dv_next[j].quo[AVG_W-1-j] = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= '0;
    end else if (en) begin
      dv_valid_q <= {dv_valid_q[AVG_W-1:0], s1_valid_q && s1_emit_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_data_q[0] <= dv_load;
      for (int j = 0; j < AVG_W; j++) begin
        dv_data_q[j+1] <= dv_next[j];
      end
    end
  end

  // result item
  assign avg_o.valid              = dv_valid_q[AVG_W];
  assign avg_o.payload.average    = dv_data_q[AVG_W].quo;
  assign avg_o.payload.out_col    = dv_data_q[AVG_W].col;
  assign avg_o.payload.out_row    = dv_data_q[AVG_W].row;
  assign avg_o.payload.frame_last = dv_data_q[AVG_W].last;

endmodule
